>>> src/emgfa_pkg.sv
package emgfa_pkg;

   // Saturation point of the per-window sample count
   localparam int WINDOW_LIMIT = 255;
   localparam logic [7:0] CNT_LIMIT = 8'(WINDOW_LIMIT);

   // Midscale flip: adc - 128 is the byte with bit 7 inverted, read as signed
   localparam logic [7:0] MIDSCALE_MASK = 8'h80;

   // Saturation limits
   localparam logic [14:0]        MAV_MAX = 15'h7FFF;
   localparam logic signed [15:0] MV_MAX  = 16'sh7FFF;
   localparam logic signed [15:0] MV_MIN  = -16'sh8000;
   localparam logic [15:0]        WFL_MAX = 16'hFFFF;
   localparam logic [7:0]         EVT_MAX = 8'hFF;

   // feature_select bit positions
   localparam int FEAT_MAV = 0;
   localparam int FEAT_MV  = 1;
   localparam int FEAT_ZX  = 2;
   localparam int FEAT_SSC = 3;
   localparam int FEAT_WFL = 4;

   // Register indexes
   localparam logic [7:0] CSR_FEATURE_SELECT = 8'd0;
   localparam logic [7:0] CSR_ZX_THRESHOLD   = 8'd1;
   localparam logic [7:0] CSR_SSC_THRESHOLD  = 8'd2;

   localparam logic [4:0] FEATURE_SELECT_RST = 5'h1F;

   typedef struct packed {
      logic [4:0] feature_select;
      logic [7:0] zx_threshold;
      logic [7:0] ssc_threshold;
   } emgfa_cfg_type;

   // Window accumulators plus the last sample
   typedef struct packed {
      logic [14:0]        mav;
      logic signed [15:0] mv;
      logic [7:0]         zx;
      logic [7:0]         ssc;
      logic [15:0]        wfl;
      logic [7:0]         cnt;
      logic signed [7:0]  last;
   } emgfa_acc_type;

endpackage

>>> src/emgfa_update.sv
module emgfa_update (
   input  emgfa_pkg::emgfa_acc_type cur_acc,
   input  logic signed [7:0]        cur_h0,
   input  logic signed [7:0]        cur_h1,
   input  emgfa_pkg::emgfa_cfg_type cfg,
   input  logic [7:0]               adc_sample,
   input  logic                     blanked,
   input  logic                     window_start,
   output emgfa_pkg::emgfa_acc_type nxt_acc,
   output logic signed [7:0]        nxt_h0,
   output logic signed [7:0]        nxt_h1
);
   import emgfa_pkg::*;

   emgfa_acc_type      base;
   logic signed [7:0]  s;
   logic [7:0]         neg_s;
   logic [7:0]         abs_s;
   logic signed [8:0]  d1;
   logic signed [8:0]  d2;
   logic [8:0]         neg_d1;
   logic [8:0]         neg_d2;
   logic [7:0]         abs_d1;
   logic [7:0]         abs_d2;
   logic [15:0]        mav_sum;
   logic signed [16:0] mv_sum;
   logic [16:0]        wfl_sum;
   logic               zx_hit;
   logic               ssc_hit;

   // Window start clears the accumulators, not the history or last sample
   always_comb begin
      base = cur_acc;
      if (window_start) begin
         base.mav = '0;
         base.mv  = '0;
         base.zx  = '0;
         base.ssc = '0;
         base.wfl = '0;
         base.cnt = '0;
      end
   end

   // Recentered sample and the two slopes at full width
   assign s      = $signed(adc_sample ^ MIDSCALE_MASK);
   assign neg_s  = 8'(-s);
   assign abs_s  = s[7] ? neg_s : 8'(s);
   assign d1     = 9'(s) - 9'(cur_h0);
   assign d2     = 9'(cur_h0) - 9'(cur_h1);
   assign neg_d1 = 9'(-d1);
   assign neg_d2 = 9'(-d2);
   assign abs_d1 = d1[8] ? neg_d1[7:0] : d1[7:0];
   assign abs_d2 = d2[8] ? neg_d2[7:0] : d2[7:0];

   // Raw sums, one bit wider for the saturation check
   assign mav_sum = {1'b0, base.mav} + {8'd0, abs_s};
   assign mv_sum  = 17'(base.mv) + 17'(s);
   assign wfl_sum = {1'b0, base.wfl} + {9'd0, abs_d1};

   // Event detectors
   assign zx_hit  = (s[7] != cur_h0[7]) && (abs_d1 >= cfg.zx_threshold);
   assign ssc_hit = (d1[8] != d2[8]) &&
                    ((abs_d1 >= cfg.ssc_threshold) || (abs_d2 >= cfg.ssc_threshold));

   // Next state
   always_comb begin
      nxt_acc = base;
      nxt_h0  = cur_h0;
      nxt_h1  = cur_h1;
      if (!blanked) begin
         nxt_h0       = s;
         nxt_h1       = cur_h0;
         nxt_acc.last = s;
         nxt_acc.cnt  = (base.cnt < CNT_LIMIT) ? base.cnt + 8'd1 : CNT_LIMIT;
         if (cfg.feature_select[FEAT_MAV]) begin
            nxt_acc.mav = mav_sum[15] ? MAV_MAX : mav_sum[14:0];
         end
         if (cfg.feature_select[FEAT_MV]) begin
            if (mv_sum[16] != mv_sum[15]) begin
               nxt_acc.mv = mv_sum[16] ? MV_MIN : MV_MAX;
            end else begin
               nxt_acc.mv = mv_sum[15:0];
            end
         end
         if (cfg.feature_select[FEAT_ZX] && zx_hit && (base.zx != EVT_MAX)) begin
            nxt_acc.zx = base.zx + 8'd1;
         end
         if (cfg.feature_select[FEAT_SSC] && ssc_hit && (base.ssc != EVT_MAX)) begin
            nxt_acc.ssc = base.ssc + 8'd1;
         end
         if (cfg.feature_select[FEAT_WFL]) begin
            nxt_acc.wfl = wfl_sum[16] ? WFL_MAX : wfl_sum[15:0];
         end
      end
   end

endmodule

>>> src/emg_feature_accumulator_core.sv
// A request beat is taken into the input register; when the result register is free or is
// being read, the beat's result is loaded there and rsp_valid rises in the same cycle.
// Throughput: one beat per cycle unless rsp_ready stalls; input and result registers part the
// two channels, so one beat can sit in the input register while a result waits for rsp_ready.
// Reset (synchronous, active high): clears history, accumulators and valid flags and
// loads the registers with feature_select = all enabled and both thresholds zero.
module emg_feature_accumulator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_adc_sample,
   input  logic               req_blanked,
   input  logic               req_window_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [14:0]        rsp_mav_sum,
   output logic signed [15:0] rsp_mv_sum,
   output logic [7:0]         rsp_zx_count,
   output logic [7:0]         rsp_ssc_count,
   output logic [15:0]        rsp_wfl_sum,
   output logic [7:0]         rsp_sample_count,
   output logic signed [7:0]  rsp_last_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_data
);
   import emgfa_pkg::*;

   emgfa_cfg_type     cfg_ff;
   emgfa_cfg_type     cfg_in;
   emgfa_acc_type     acc_ff;
   emgfa_acc_type     acc_in;
   emgfa_acc_type     rsp_ff;
   logic signed [7:0] h0_ff;
   logic signed [7:0] h1_ff;
   logic signed [7:0] h0_in;
   logic signed [7:0] h1_in;
   logic              in_valid_ff;
   logic [7:0]        in_sample_ff;
   logic              in_blanked_ff;
   logic              in_start_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              req_take;
   logic              move;

   // Handshake
   assign move      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (move) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FEATURE_SELECT: cfg_in.feature_select = csr_data[4:0];
            CSR_ZX_THRESHOLD:   cfg_in.zx_threshold   = csr_data;
            CSR_SSC_THRESHOLD:  cfg_in.ssc_threshold  = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Feature update
   emgfa_update u_update (
      .cur_acc      (acc_ff),
      .cur_h0       (h0_ff),
      .cur_h1       (h1_ff),
      .cfg          (cfg_ff),
      .adc_sample   (in_sample_ff),
      .blanked      (in_blanked_ff),
      .window_start (in_start_ff),
      .nxt_acc      (acc_in),
      .nxt_h0       (h0_in),
      .nxt_h1       (h1_in)
   );

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.feature_select <= FEATURE_SELECT_RST;
         cfg_ff.zx_threshold   <= '0;
         cfg_ff.ssc_threshold  <= '0;
         acc_ff <= '0;
         h0_ff  <= '0;
         h1_ff  <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            acc_ff <= acc_in;
            h0_ff  <= h0_in;
            h1_ff  <= h1_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff  <= req_adc_sample;
         in_blanked_ff <= req_blanked;
         in_start_ff   <= req_window_start;
      end
      if (move) begin
         rsp_ff <= acc_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mav_sum      = rsp_ff.mav;
   assign rsp_mv_sum       = rsp_ff.mv;
   assign rsp_zx_count     = rsp_ff.zx;
   assign rsp_ssc_count    = rsp_ff.ssc;
   assign rsp_wfl_sum      = rsp_ff.wfl;
   assign rsp_sample_count = rsp_ff.cnt;
   assign rsp_last_sample  = rsp_ff.last;

   // Checks
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      acc_ff.cnt <= CNT_LIMIT)
      else $error("sample count above window limit");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_take && in_valid_ff && !move))
      else $error("request beat taken into a full input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !move) |=> in_valid_ff)
      else $error("stalled input beat lost");

   a_blank_history: assert property (@(posedge clock) disable iff (reset)
      (move && in_blanked_ff) |=> ($stable(h0_ff) && $stable(h1_ff)))
      else $error("blanked beat changed the history");

   a_move_shows: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("result lost after update");

endmodule

>>> tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import emgfa_pkg::*;

   localparam int MIDSCALE     = 128;
   localparam int STALL_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [7:0] adc;
      logic       blanked;
      logic       start;
   } emg_sample_type;

   // Value profile of a generated window
   typedef enum logic [1:0] {
      SHAPE_MIX,
      SHAPE_SWING,
      SHAPE_FLOOR,
      SHAPE_CEIL
   } window_shape_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_adc_sample = 8'd0;
   logic               req_blanked = 1'b0;
   logic               req_window_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [14:0]        rsp_mav_sum;
   logic signed [15:0] rsp_mv_sum;
   logic [7:0]         rsp_zx_count;
   logic [7:0]         rsp_ssc_count;
   logic [15:0]        rsp_wfl_sum;
   logic [7:0]         rsp_sample_count;
   logic signed [7:0]  rsp_last_sample;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_index = 8'd0;
   logic [7:0]         csr_data = 8'd0;

   // Stimulus and expected window values
   emg_sample_type sample_q[$];
   emgfa_acc_type  window_stats_q[$];

   // Feature model: registers, history and window accumulators
   emgfa_cfg_type     cfg_model;
   logic signed [7:0] hist_model [3];
   emgfa_acc_type     acc_model;

   int  mismatch_count = 0;
   int  results_seen = 0;
   int  samples_sent = 0;
   int  windows_opened = 0;
   int  settings_used = 0;
   int  stall_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  hold_started = 1'b0;
   bit  beat_taken = 1'b0;

   emg_feature_accumulator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_sample   (req_adc_sample),
      .req_blanked      (req_blanked),
      .req_window_start (req_window_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mav_sum      (rsp_mav_sum),
      .rsp_mv_sum       (rsp_mv_sum),
      .rsp_zx_count     (rsp_zx_count),
      .rsp_ssc_count    (rsp_ssc_count),
      .rsp_wfl_sum      (rsp_wfl_sum),
      .rsp_sample_count (rsp_sample_count),
      .rsp_last_sample  (rsp_last_sample),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Fold one accepted beat into the window model, return the values to report
   function automatic emgfa_acc_type fold_sample(input emg_sample_type beat);
      int s, h0, h1, h2, d1, d2, sum;
      if (beat.start) begin
         acc_model.mav = '0;
         acc_model.mv  = '0;
         acc_model.zx  = '0;
         acc_model.ssc = '0;
         acc_model.wfl = '0;
         acc_model.cnt = '0;
      end
      if (!beat.blanked) begin
         s = int'(beat.adc) - MIDSCALE;
         hist_model[2] = hist_model[1];
         hist_model[1] = hist_model[0];
         hist_model[0] = 8'(s);
         h0 = hist_model[0];
         h1 = hist_model[1];
         h2 = hist_model[2];
         d1 = h0 - h1;
         d2 = h1 - h2;

         if (acc_model.cnt < CNT_LIMIT) acc_model.cnt = acc_model.cnt + 8'd1;
         acc_model.last = 8'(s);

         if (cfg_model.feature_select[FEAT_MAV]) begin
            sum = int'(acc_model.mav) + magnitude(s);
            acc_model.mav = (sum > int'(MAV_MAX)) ? MAV_MAX : 15'(sum);
         end
         if (cfg_model.feature_select[FEAT_MV]) begin
            sum = int'($signed(acc_model.mv)) + s;
            if (sum > int'(MV_MAX)) sum = int'(MV_MAX);
            if (sum < int'(MV_MIN)) sum = int'(MV_MIN);
            acc_model.mv = 16'(sum);
         end
         // crossing: sign bits differ and the full-width jump meets the threshold
         if (cfg_model.feature_select[FEAT_ZX]) begin
            if (((h0 < 0) != (h1 < 0)) &&
                (magnitude(d1) >= int'(cfg_model.zx_threshold)) &&
                (acc_model.zx != EVT_MAX))
               acc_model.zx = acc_model.zx + 8'd1;
         end
         // slope change: zero slope counts as non-negative
         if (cfg_model.feature_select[FEAT_SSC]) begin
            if (((d1 < 0) != (d2 < 0)) &&
                ((magnitude(d1) >= int'(cfg_model.ssc_threshold)) ||
                 (magnitude(d2) >= int'(cfg_model.ssc_threshold))) &&
                (acc_model.ssc != EVT_MAX))
               acc_model.ssc = acc_model.ssc + 8'd1;
         end
         if (cfg_model.feature_select[FEAT_WFL]) begin
            sum = int'(acc_model.wfl) + magnitude(d1);
            acc_model.wfl = (sum > int'(WFL_MAX)) ? WFL_MAX : 16'(sum);
         end
      end
      return acc_model;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
      end
   endtask

   // Sender: new beat or idle burst at the falling edge
   always @(negedge clock) begin
      emg_sample_type next_beat;
      if (!reset) begin
         if (!req_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               next_beat = sample_q.pop_front();
               req_valid        <= 1'b1;
               req_adc_sample   <= next_beat.adc;
               req_blanked      <= next_beat.blanked;
               req_window_start <= next_beat.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready with random stall bursts and one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_request && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: check results, then record accepted beats and register writes
   always @(posedge clock) begin
      emgfa_acc_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
         end

         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (window_stats_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result %0d arrived with nothing expected", results_seen);
            end else begin
               want = window_stats_q.pop_front();
               check_field("mav_sum", want.mav, rsp_mav_sum);
               check_field("mv_sum", $signed(want.mv), rsp_mv_sum);
               check_field("zx_count", want.zx, rsp_zx_count);
               check_field("ssc_count", want.ssc, rsp_ssc_count);
               check_field("wfl_sum", want.wfl, rsp_wfl_sum);
               check_field("sample_count", want.cnt, rsp_sample_count);
               check_field("last_sample", $signed(want.last), rsp_last_sample);
            end
         end

         if (req_valid && req_ready) begin
            window_stats_q.push_back(fold_sample('{adc: req_adc_sample,
                                                   blanked: req_blanked,
                                                   start: req_window_start}));
            samples_sent++;
            beat_taken = 1'b1;
         end

         // unknown indexes fall through; upper data bits are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FEATURE_SELECT: cfg_model.feature_select = csr_data[4:0];
               CSR_ZX_THRESHOLD:   cfg_model.zx_threshold   = csr_data;
               CSR_SSC_THRESHOLD:  cfg_model.ssc_threshold  = csr_data;
               default: ;
            endcase
         end
      end
   end

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Block is idle once nothing is queued, offered or outstanding
   task automatic settle();
      @(posedge clock);
      while (sample_q.size() != 0 || req_valid || window_stats_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic begin_phase(input logic [7:0] sel, input logic [7:0] zx_thr,
                              input logic [7:0] ssc_thr, input int idle_pct);
      settle();
      write_reg(CSR_FEATURE_SELECT, sel);
      write_reg(CSR_ZX_THRESHOLD, zx_thr);
      write_reg(CSR_SSC_THRESHOLD, ssc_thr);
      send_idle_pct = idle_pct;
      recv_idle_pct = idle_pct;
      settings_used++;
   endtask

   function automatic logic [7:0] pick_threshold();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      return 8'($urandom_range(1, 24));
   endfunction

   task automatic queue_beat(input logic [7:0] adc, input logic blanked, input logic start);
      sample_q.push_back('{adc: adc, blanked: blanked, start: start});
      if (start) windows_opened++;
   endtask

   // Long shaped windows carry no blanking so they are sure to saturate
   task automatic queue_window(input window_shape_type shape, input int len, input bit opens);
      logic [7:0] adc;
      logic       blanked;
      int         r;
      for (int i = 0; i < len; i++) begin
         case (shape)
            SHAPE_SWING: adc = (i % 2 == 0) ? 8'($urandom_range(0, 3))
                                            : 8'($urandom_range(252, 255));
            SHAPE_FLOOR: adc = 8'($urandom_range(0, 2));
            SHAPE_CEIL:  adc = 8'($urandom_range(253, 255));
            default: begin
               r = $urandom_range(0, 9);
               if (r < 5)
                  adc = 8'($urandom_range(0, 255));
               else if (r < 8)
                  adc = 8'($urandom_range(112, 144));
               else
                  adc = $urandom_range(0, 1) ? 8'($urandom_range(250, 255))
                                             : 8'($urandom_range(0, 5));
            end
         endcase
         blanked = (shape == SHAPE_MIX) ? ($urandom_range(0, 7) == 0) : 1'b0;
         queue_beat(adc, blanked, (i == 0) && opens);
      end
   endtask

   task automatic queue_mix(input int total);
      int n;
      int len;
      n = 0;
      while (n < total) begin
         len = $urandom_range(1, 24);
         queue_window(SHAPE_MIX, len, $urandom_range(0, 5) != 0);
         n += len;
      end
   endtask

   initial begin
      window_shape_type long_shape;

      cfg_model = '{feature_select: FEATURE_SELECT_RST, zx_threshold: 8'd0,
                    ssc_threshold: 8'd0};
      acc_model = '0;
      hist_model[0] = '0;
      hist_model[1] = '0;
      hist_model[2] = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zero history, full-width jumps, flat slopes, blanking
      queue_beat(8'd128, 1'b0, 1'b0);
      queue_beat(8'd0,   1'b0, 1'b0);
      queue_beat(8'd255, 1'b0, 1'b0);
      queue_beat(8'd0,   1'b0, 1'b0);
      queue_beat(8'd127, 1'b0, 1'b0);
      queue_beat(8'd129, 1'b0, 1'b0);
      queue_beat(8'd129, 1'b0, 1'b0);
      queue_beat(8'd127, 1'b0, 1'b0);
      queue_beat(8'd255, 1'b1, 1'b0);
      queue_beat(8'd0,   1'b1, 1'b1);
      queue_beat(8'd200, 1'b0, 1'b0);
      queue_beat(8'd200, 1'b0, 1'b1);
      queue_beat(8'h55,  1'b0, 1'b0);
      queue_beat(8'hAA,  1'b0, 1'b0);
      queue_beat(8'd1,   1'b0, 1'b0);
      queue_beat(8'd254, 1'b0, 1'b0);
      queue_beat(8'd128, 1'b0, 1'b0);
      settings_used++;

      // Thresholds right at and just past the jump size
      begin_phase(8'h1F, 8'd128, 8'd129, 0);
      queue_beat(8'd128, 1'b0, 1'b1);
      queue_beat(8'd0,   1'b0, 1'b0);
      queue_beat(8'd128, 1'b0, 1'b0);
      queue_beat(8'd1,   1'b0, 1'b0);
      queue_beat(8'd129, 1'b0, 1'b0);
      queue_beat(8'd0,   1'b0, 1'b0);

      // Long windows that drive the sums and counts into saturation
      begin_phase(8'h1F, 8'd0, 8'd0, 25);
      queue_window(SHAPE_SWING, $urandom_range(266, 272), 1'b1);
      if ($urandom_range(0, 1) != 0)
         long_shape = SHAPE_FLOOR;
      else
         long_shape = SHAPE_CEIL;
      begin_phase(8'hFF, pick_threshold(), pick_threshold(), 25);
      queue_window(long_shape, $urandom_range(266, 272), 1'b1);

      // All features off: accumulators hold, stray indexes do nothing
      begin_phase(8'h00, 8'd255, 8'd255, 25);
      write_reg(8'd3, 8'($urandom_range(0, 255)));
      write_reg(8'hFF, 8'($urandom_range(0, 255)));
      queue_window(SHAPE_MIX, 16, 1'b0);

      // Receiver holds off while the sender keeps pushing
      begin_phase(8'($urandom_range(0, 31)), pick_threshold(), pick_threshold(), 25);
      hold_request = 1'b1;
      queue_mix(16);

      for (int p = 0; p < 2; p++) begin
         begin_phase(8'($urandom_range(0, 31)), pick_threshold(), pick_threshold(),
                     (p % 2 == 0) ? 25 : 0);
         queue_mix(8);
      end

      // Quiet tail, no idling
      begin_phase(8'h1F, pick_threshold(), pick_threshold(), 0);
      queue_mix(16);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results for %0d samples in %0d windows under %0d settings.",
               results_seen, samples_sent, windows_opened, settings_used);
      $display("Covered saturation of every sum and count (signed sum at one rail), %s",
               "blanking, disabled features, a long receiver hold-off and idle bursts.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
src/emgfa_pkg.sv
src/emgfa_update.sv
src/emg_feature_accumulator_core.sv
tb/tb_top.sv
